// ===== design/stereo_disparity_triangulation_assert.svh =====
// ----------------------------------------------------------------------------
// Stereo triangulation assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STEREO_DISPARITY_TRIANGULATION_ASSERT_SVH
`define STEREO_DISPARITY_TRIANGULATION_ASSERT_SVH
`ifndef SYNTH
`define SDT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define SDT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/sdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_pkg
// Types, widths and saturation helpers for stereo triangulation.
// ----------------------------------------------------------------------------
package sdt_pkg;
	localparam int NUM_W   = 56;
	localparam int DEN_W   = 36;
	localparam int QUO_W   = 33;
	localparam int DIV_LAT = QUO_W + 1;
	localparam int LATENCY = 4 + DIV_LAT + 1;
	localparam int DISP_MIN = 7;

	localparam logic [2:0] REG_FOCAL_X  = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
	localparam logic [2:0] REG_CENTER_X = 3'd2;
	localparam logic [2:0] REG_CENTER_Y = 3'd3;
	localparam logic [2:0] REG_BASELINE = 3'd4;

	typedef struct packed {
		logic        v;
		logic        ok;
		logic [18:0] disp;
		logic        nx;
		logic        ny;
		logic [15:0] conf;
		logic        side;
	} side_t;

	typedef struct packed {
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} div_res_t;

	function automatic logic [31:0] sat_u32(div_res_t r);
		logic [31:0] res;
		res = (r.ovf || r.quo[QUO_W-1]) ? 32'hFFFF_FFFF : r.quo[31:0];
		return res;
	endfunction

	function automatic logic [31:0] sat_s32(logic neg, div_res_t r);
		logic [QUO_W-1:0] mag;
		logic [QUO_W-1:0] negv;
		logic [31:0] res;
		if (neg) begin
			mag = (r.ovf || r.quo > 33'h0_8000_0000) ? 33'h0_8000_0000 : r.quo;
			negv = 33'd0 - mag;
			res = negv[31:0];
		end else begin
			res = (r.ovf || r.quo > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r.quo[31:0];
		end
		return res;
	endfunction
endpackage

// ===== design/sdt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_div
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
// ----------------------------------------------------------------------------
module sdt_div (
	input  logic                      clk,
	input  logic [sdt_pkg::NUM_W-1:0] num,
	input  logic [sdt_pkg::DEN_W-1:0] den,
	output sdt_pkg::div_res_t         res
);
	localparam int XW = sdt_pkg::DEN_W + sdt_pkg::QUO_W;

	logic [sdt_pkg::NUM_W-1:0] rem_s [sdt_pkg::QUO_W+1];
	logic [sdt_pkg::DEN_W-1:0] den_s [sdt_pkg::QUO_W+1];
	logic [sdt_pkg::QUO_W-1:0] quo_s [sdt_pkg::QUO_W+1];
	logic                      ovf_s [sdt_pkg::QUO_W+1];

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= {{(XW-sdt_pkg::NUM_W){1'b0}}, num} >=
			{den, {sdt_pkg::QUO_W{1'b0}}};
	end

	for (genvar j = 0; j < sdt_pkg::QUO_W; j++) begin : g_stage
		localparam int B = sdt_pkg::QUO_W - 1 - j;
		logic [XW-1:0] rem_x;
		logic [XW-1:0] den_x;
		logic [XW-1:0] diff;
		logic          ge;
		assign rem_x = {{(XW-sdt_pkg::NUM_W){1'b0}}, rem_s[j]};
		assign den_x = {{sdt_pkg::QUO_W{1'b0}}, den_s[j]} << B;
		assign ge    = rem_x >= den_x;
		assign diff  = rem_x - den_x;
		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? diff[sdt_pkg::NUM_W-1:0] : rem_s[j];
			den_s[j+1] <= den_s[j];
			quo_s[j+1] <= quo_s[j] | ({{(sdt_pkg::QUO_W-1){1'b0}}, ge} << B);
			ovf_s[j+1] <= ovf_s[j];
		end
	end

	assign res.ovf = ovf_s[sdt_pkg::QUO_W];
	assign res.quo = quo_s[sdt_pkg::QUO_W];
endmodule

// ===== design/stereo_disparity_triangulation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_disparity_triangulation
// Throughput: one item per cycle; busy is never raised.
// Depth set by the dividers (input register, then 33 bit-per-stage stages) after 4 prep stages.
// arst_n clears valid bits and config to calibration defaults.
// Results appear for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "stereo_disparity_triangulation_assert.svh"
module stereo_disparity_triangulation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [17:0]        left_col,
	input  logic [17:0]        left_row,
	input  logic [17:0]        right_col,
	input  logic               left_seen,
	input  logic               right_seen,
	input  logic [15:0]        left_conf,
	input  logic [15:0]        right_conf,
	input  logic               eye_side,
	output logic               done,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [31:0]        pos_z,
	output logic signed [18:0] pixel_disparity,
	output logic [15:0]        mean_conf,
	output logic               pos_valid,
	output logic               side_out
);
	logic [17:0] fx_q, fy_q, cx_q, cy_q;
	logic [19:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q   <= 18'd32000;
			fy_q   <= 18'd32000;
			cx_q   <= 18'd20480;
			cy_q   <= 18'd15360;
			base_q <= 20'd3932;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				sdt_pkg::REG_FOCAL_X:  fx_q   <= cfg_wdata[17:0];
				sdt_pkg::REG_FOCAL_Y:  fy_q   <= cfg_wdata[17:0];
				sdt_pkg::REG_CENTER_X: cx_q   <= cfg_wdata[17:0];
				sdt_pkg::REG_CENTER_Y: cy_q   <= cfg_wdata[17:0];
				sdt_pkg::REG_BASELINE: base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: capture
	logic        v_s1, both_s1, side_s1;
	logic [17:0] lx_s1, ly_s1, rx_s1;
	logic [15:0] lc_s1, rc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start && !busy;
	end
	always_ff @(posedge clk) begin
		lx_s1   <= left_col;
		ly_s1   <= left_row;
		rx_s1   <= right_col;
		both_s1 <= left_seen && right_seen;
		lc_s1   <= left_conf;
		rc_s1   <= right_conf;
		side_s1 <= eye_side;
	end

	// stage 2: disparity, offsets, fx*B
	logic [18:0] d_c;
	logic [16:0] csum_c;
	logic        ok_c;
	sdt_pkg::side_t sb_s2, sb_s3, sb_s4;
	logic [17:0] d_s2, ax_s2, ay_s2, fy_s2;
	logic [37:0] fb_s2;

	assign d_c    = {1'b0, lx_s1} - {1'b0, rx_s1};
	assign csum_c = {1'b0, lc_s1} + {1'b0, rc_s1};
	assign ok_c   = both_s1 && !d_c[18] && (d_c >= 19'(sdt_pkg::DISP_MIN));

	// sideband travels with the item through stages 2 to 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s2 <= '0;
			sb_s3 <= '0;
			sb_s4 <= '0;
		end else begin
			sb_s2.v    <= v_s1;
			sb_s2.ok   <= ok_c;
			sb_s2.disp <= both_s1 ? d_c : 19'd0;
			sb_s2.nx   <= lx_s1 < cx_q;
			sb_s2.ny   <= ly_s1 < cy_q;
			sb_s2.conf <= csum_c[16:1];
			sb_s2.side <= side_s1;
			sb_s3      <= sb_s2;
			sb_s4      <= sb_s3;
		end
	end
	always_ff @(posedge clk) begin
		d_s2  <= d_c[17:0];
		ax_s2 <= (lx_s1 < cx_q) ? cx_q - lx_s1 : lx_s1 - cx_q;
		ay_s2 <= (ly_s1 < cy_q) ? cy_q - ly_s1 : ly_s1 - cy_q;
		fy_s2 <= (fy_q == 18'd0) ? 18'd1 : fy_q;
		fb_s2 <= fx_q * base_q;
	end

	// stage 3: products
	logic [37:0] axb_s3, fb_s3;
	logic [35:0] dfy_s3;
	logic [17:0] d_s3;
	logic [36:0] plo_s3, phi_s3;

	always_ff @(posedge clk) begin
		axb_s3 <= ax_s2 * base_q;
		dfy_s3 <= d_s2 * fy_s2;
		plo_s3 <= ay_s2 * fb_s2[18:0];
		phi_s3 <= ay_s2 * fb_s2[37:19];
		fb_s3  <= fb_s2;
		d_s3   <= d_s2;
	end

	// stage 4: combine partial products
	logic [sdt_pkg::NUM_W-1:0] ayfb_s4, fb_s4, axb_s4;
	logic [sdt_pkg::DEN_W-1:0] dfy_s4, d_s4;

	always_ff @(posedge clk) begin
		ayfb_s4 <= {phi_s3[36:0], 19'd0} + {19'd0, plo_s3};
		fb_s4   <= {18'd0, fb_s3};
		axb_s4  <= {18'd0, axb_s3};
		dfy_s4  <= dfy_s3;
		d_s4    <= {18'd0, d_s3};
	end

	sdt_pkg::div_res_t z_res, x_res, y_res;

	sdt_div u_div_z (.clk(clk), .num(fb_s4),   .den(d_s4),   .res(z_res));
	sdt_div u_div_x (.clk(clk), .num(axb_s4),  .den(d_s4),   .res(x_res));
	sdt_div u_div_y (.clk(clk), .num(ayfb_s4), .den(dfy_s4), .res(y_res));

	sdt_pkg::side_t sb_dly_q [sdt_pkg::DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sdt_pkg::DIV_LAT; i++) sb_dly_q[i] <= '0;
		end else begin
			sb_dly_q[0] <= sb_s4;
			for (int i = 1; i < sdt_pkg::DIV_LAT; i++) sb_dly_q[i] <= sb_dly_q[i-1];
		end
	end

	sdt_pkg::side_t sb_end;
	assign sb_end = sb_dly_q[sdt_pkg::DIV_LAT-1];

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= sb_end.v;
	end
	always_ff @(posedge clk) begin
		pixel_disparity <= sb_end.disp;
		side_out        <= sb_end.side;
		pos_valid       <= sb_end.ok;
		if (sb_end.ok) begin
			pos_z     <= sdt_pkg::sat_u32(z_res);
			pos_x     <= sdt_pkg::sat_s32(sb_end.nx, x_res);
			pos_y     <= sdt_pkg::sat_s32(sb_end.ny, y_res);
			mean_conf <= sb_end.conf;
		end else begin
			pos_z     <= '0;
			pos_x     <= '0;
			pos_y     <= '0;
			mean_conf <= '0;
		end
	end
	assign done = done_q;

	`SDT_ASSERT_IMP(a_latency, clk, arst_n, start && !busy, ##39 done, "done strobe missing")
	`SDT_ASSERT_IMP(a_zero_inval, clk, arst_n, done && !pos_valid,
		pos_x == 0 && pos_y == 0 && pos_z == 0 && mean_conf == 0, "invalid item not zeroed")
	`SDT_ASSERT_IMP(a_disp_min, clk, arst_n, done && pos_valid,
		!pixel_disparity[18] && pixel_disparity >= 19'sd7, "valid with small disparity")
	`SDT_ASSERT(a_no_busy, clk, arst_n, !busy, "busy raised")
endmodule

// ===== tb/stereo_triangulation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo triangulation checker
// Watches accepted items and done strobes, computes the expected position,
// disparity, confidence, valid and side for each item, and compares them in order.
// ----------------------------------------------------------------------------
module stereo_triangulation_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_wdata,
	input  logic               start,
	input  logic               busy,
	input  logic [17:0]        left_col,
	input  logic [17:0]        left_row,
	input  logic [17:0]        right_col,
	input  logic               left_seen,
	input  logic               right_seen,
	input  logic [15:0]        left_conf,
	input  logic [15:0]        right_conf,
	input  logic               eye_side,
	input  logic               done,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [31:0]        pos_z,
	input  logic signed [18:0] pixel_disparity,
	input  logic [15:0]        mean_conf,
	input  logic               pos_valid,
	input  logic               side_out,
	output int                 fail_count,
	output int                 pending
);
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [18:0] disp;
		logic [15:0] conf;
		logic        valid;
		logic        side;
	} eye_pos_t;

	logic [17:0] fx, fy, cx, cy;
	logic [19:0] base;
	eye_pos_t    pos_q[$];

	function automatic logic [31:0] clamp_signed(logic neg, logic [63:0] q);
		if (neg) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			return 32'(64'd0 - q);
		end
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic eye_pos_t triangulate();
		eye_pos_t    r;
		logic [63:0] d, fb, den, ax, ay;
		logic        nx, ny;
		r = '0;
		r.side = eye_side;
		if (left_seen && right_seen) begin
			r.disp = 19'({1'b0, left_col} - {1'b0, right_col});
			if (left_col >= right_col && left_col - right_col >= sdt_pkg::DISP_MIN) begin
				d = 64'(left_col - right_col);
				fb = 64'(fx) * 64'(base);
				den = d * ((fy != 0) ? 64'(fy) : 64'd1);
				nx = left_col < cx;
				ny = left_row < cy;
				ax = nx ? 64'(cx - left_col) : 64'(left_col - cx);
				ay = ny ? 64'(cy - left_row) : 64'(left_row - cy);
				r.z = (fb / d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(fb / d);
				r.x = clamp_signed(nx, (ax * 64'(base)) / d);
				r.y = clamp_signed(ny, (ay * fb) / den);
				r.conf = 16'((17'(left_conf) + 17'(right_conf)) >> 1);
				r.valid = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		eye_pos_t e;
		if (!arst_n) begin
			fx <= 18'd32000;
			fy <= 18'd32000;
			cx <= 18'd20480;
			cy <= 18'd15360;
			base <= 20'd3932;
			fail_count <= 0;
			pending <= 0;
			pos_q.delete();
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					sdt_pkg::REG_FOCAL_X:  fx <= cfg_wdata[17:0];
					sdt_pkg::REG_FOCAL_Y:  fy <= cfg_wdata[17:0];
					sdt_pkg::REG_CENTER_X: cx <= cfg_wdata[17:0];
					sdt_pkg::REG_CENTER_Y: cy <= cfg_wdata[17:0];
					sdt_pkg::REG_BASELINE: base <= cfg_wdata;
					default: ;
				endcase
			end
			if (done) begin
				if (pos_q.size() == 0) begin
					$display("%0t: result with nothing expected: x=%h y=%h z=%h", $time,
						pos_x, pos_y, pos_z);
					fail_count <= fail_count + 1;
				end else begin
					e = pos_q.pop_front();
					if (e != {pos_x, pos_y, pos_z, pixel_disparity, mean_conf,
						pos_valid, side_out}) begin
						$display("%0t: mismatch expected x=%h y=%h z=%h d=%h c=%h v=%b s=%b",
							$time, e.x, e.y, e.z, e.disp, e.conf, e.valid, e.side);
						$display("%0t:          actual   x=%h y=%h z=%h d=%h c=%h v=%b s=%b",
							$time, pos_x, pos_y, pos_z, pixel_disparity, mean_conf,
							pos_valid, side_out);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				pos_q.push_back(triangulate());
			pending <= pos_q.size();
		end
	end
endmodule

// ===== tb/tb_stereo_disparity_triangulation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo triangulation testbench
// Directed corner items, then random stereo detections under several
// calibrations, with random start gaps and a back-to-back run; results checked by the checker.
// ----------------------------------------------------------------------------
module tb_stereo_disparity_triangulation;
	logic               clk, arst_n, cfg_wen, start, busy, done;
	logic [2:0]         cfg_index;
	logic [19:0]        cfg_wdata;
	logic [17:0]        left_col, left_row, right_col;
	logic               left_seen, right_seen, eye_side;
	logic [15:0]        left_conf, right_conf;
	logic signed [31:0] pos_x, pos_y;
	logic [31:0]        pos_z;
	logic signed [18:0] pixel_disparity;
	logic [15:0]        mean_conf;
	logic               pos_valid, side_out;
	int                 fail_count, pending;
	int                 cycles;
	bit                 no_gaps;

	stereo_disparity_triangulation u_top (.*);
	stereo_triangulation_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 200000) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic calibrate(input logic [17:0] f_x, f_y, c_x, c_y, input logic [19:0] b);
		write_reg(sdt_pkg::REG_FOCAL_X, 20'(f_x));
		write_reg(sdt_pkg::REG_FOCAL_Y, 20'(f_y));
		write_reg(sdt_pkg::REG_CENTER_X, 20'(c_x));
		write_reg(sdt_pkg::REG_CENTER_Y, 20'(c_y));
		write_reg(sdt_pkg::REG_BASELINE, b);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (sdt_pkg::LATENCY + 5) @(posedge clk);
	endtask

	// one item; start stays high across back-to-back items
	task automatic send(input logic [17:0] lx, ly, rx, input logic ls, rs,
		input logic [15:0] lc, rc, input logic sd);
		while (!no_gaps && $urandom_range(99) < 27) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		left_col <= lx;
		left_row <= ly;
		right_col <= rx;
		left_seen <= ls;
		right_seen <= rs;
		left_conf <= lc;
		right_conf <= rc;
		eye_side <= sd;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_random(input int n);
		logic [17:0] lx, rx, d;
		logic        free_rx;
		repeat (n) begin
			lx = 18'($urandom);
			rx = 18'($urandom);
			d = '0;
			free_rx = 1'b0;
			case ($urandom_range(9))
				0: free_rx = 1'b1;
				1: d = 18'($urandom_range(12)) ;
				2: d = 18'($urandom_range(262143));
				default: d = 18'($urandom_range(20000, 7));
			endcase
			if (!free_rx && $urandom_range(9) != 0) begin
				if ($urandom_range(9) == 1) d = 18'($urandom_range(12));
				if (lx < d) lx = lx + d;
				rx = lx - d;
			end
			send(lx, 18'($urandom), rx, $urandom_range(9) != 0, $urandom_range(9) != 0,
				16'($urandom), 16'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_wen = 0; cfg_index = '0; cfg_wdata = '0; start = 0;
		left_col = '0; left_row = '0; right_col = '0; left_seen = 0; right_seen = 0;
		left_conf = '0; right_conf = '0; eye_side = 0; no_gaps = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset calibration
		send(18'd30000, 18'd20000, 18'd29000, 1, 1, 16'hFFFF, 16'hFFFF, 1);
		send(18'd30000, 18'd20000, 18'd29000, 0, 1, 16'h1234, 16'h4321, 0);
		send(18'd30000, 18'd20000, 18'd29000, 1, 0, 16'h1234, 16'h4321, 1);
		send(18'd30000, 18'd20000, 18'd29000, 0, 0, 16'h1234, 16'h4321, 0);
		send(18'd1000, 18'd1000, 18'd994, 1, 1, 16'd1, 16'd0, 0);
		send(18'd1000, 18'd1000, 18'd993, 1, 1, 16'd1, 16'd2, 1);
		send(18'd1000, 18'd1000, 18'd1000, 1, 1, 16'd5, 16'd5, 0);
		send(18'd0, 18'd0, 18'h3FFFF, 1, 1, 16'd5, 16'd5, 1);
		send(18'h3FFFF, 18'h3FFFF, 18'd0, 1, 1, 16'hFFFF, 16'd0, 0);
		send(18'd7, 18'd0, 18'd0, 1, 1, 16'd0, 16'd0, 1);
		send(18'd20480, 18'd15360, 18'd20400, 1, 1, 16'd100, 16'd300, 0);
		drain();

		// extremes: huge focal and baseline saturate, zero focal, zero baseline
		calibrate(18'h3FFFF, 18'd64, 18'h3FFFF, 18'h3FFFF, 20'hFFFFF);
		send(18'd7, 18'd0, 18'd0, 1, 1, 16'd9, 16'd8, 0);
		send(18'h3FFFF, 18'h3FFFF, 18'd0, 1, 1, 16'd9, 16'd8, 1);
		send(18'd8, 18'd0, 18'd1, 1, 1, 16'd9, 16'd8, 0);
		send_random(40);
		drain();
		calibrate(18'd0, 18'd0, 18'd0, 18'd0, 20'd0);
		send(18'd50000, 18'd40000, 18'd100, 1, 1, 16'd9, 16'd8, 1);
		drain();
		write_reg(sdt_pkg::REG_BASELINE, 20'hFFFFF);
		send(18'd50000, 18'd40000, 18'd100, 1, 1, 16'd9, 16'd8, 1);
		send(18'd7, 18'h3FFFF, 18'd0, 1, 1, 16'd9, 16'd8, 0);
		send_random(40);
		drain();

		// random calibrations
		repeat (4) begin
			calibrate(18'($urandom_range(262143, 64)), 18'($urandom_range(262143, 64)),
				18'($urandom), 18'($urandom), 20'($urandom));
			send_random(60);
			drain();
		end

		// typical calibration, back-to-back then gappy
		calibrate(18'd32000, 18'd31000, 18'd20480, 18'd15360, 20'd3932);
		no_gaps = 1;
		send_random(100);
		no_gaps = 0;
		send_random(110);
		drain();

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
